FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/bhtp_pkg.sv
// Package for the branch history table predictor.
// Constants, codes and controller/datapath interface structs; no dependencies.
package bhtp_pkg;

    localparam int LOG_TABLE_SIZE_DEF = 15;

    localparam int        CTR_W     = 2;
    localparam logic [1:0] CTR_RESET = 2'd2;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_MIN   = 2'd0;

    localparam int         MODE_W      = 2;
    localparam logic [1:0] MODE_LOCAL  = 2'd0;
    localparam logic [1:0] MODE_GLOBAL = 2'd1;
    localparam logic [1:0] MODE_GSHARE = 2'd2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;  // write reset value at clear address, advance it
        logic load;    // capture an accepted input transaction
        logic rd_en;   // read counter table at captured index
        logic eval;    // finish the item: write back or load result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clear address is at the last entry
        logic is_update;  // captured item is an update
        logic out_free;   // result register can take a new result
    } t_dp_sts;

endpackage

FILE: design/branch_history_table_predictor_core.sv
// Top level of the branch history table predictor (2-bit counters,
// local / global / gshare indexing). Depends on bhtp_pkg, bhtp_ctrl,
// bhtp_datapath and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_command, i_branch_address,
//          |           |                            | i_was_taken
//  out     | out       | o_out_valid / i_out_stall  | o_predict_taken
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_index_mode
//
// An item passes through accept, counter table read (registered read
// port), then evaluate/write back. A predict waits in evaluate while the
// result register is full and stalled; an update never waits.
// After reset a clearing pass writes weakly taken into every one of the
// 2**LOG_TABLE_SIZE counters (32768 by default); input stays stalled meanwhile.
// Config writes are taken in every cycle.
module branch_history_table_predictor_core #(
    parameter int LOG_TABLE_SIZE = bhtp_pkg::LOG_TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input transaction channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [63:0]                 i_branch_address,
    input  logic                        i_was_taken,
    // result transaction channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_predict_taken,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bhtp_pkg::MODE_W-1:0] i_index_mode
);
    import bhtp_pkg::*;

    `include "assert_macros.svh"

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // mode register has no busy condition
    assign o_cfg_ready = 1'b1;

    bhtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    bhtp_datapath #(
        .LOG_TABLE_SIZE (LOG_TABLE_SIZE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_index_mode     (i_index_mode),
        .i_command        (i_command),
        .i_branch_address (i_branch_address),
        .i_was_taken      (i_was_taken),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_predict_taken  (o_predict_taken)
    );

    // no transaction accepted while the table is being cleared
    `ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, !o_in_stall, !dp_cmd.clr_en)
    // one item at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // every table read is followed by the evaluate step or a wait for it
    `ASSERT_NEXT(a_read_then_eval, i_clk, i_rst_n, dp_cmd.rd_en, !dp_cmd.rd_en && !dp_cmd.load)
    // a new result only comes out of a predict evaluation
    `ASSERT_IMPLIES(a_result_from_eval, i_clk, i_rst_n, $rose(o_out_valid),
                    $past(dp_cmd.eval) && !$past(dp_sts.is_update))

endmodule

FILE: design/bhtp_ctrl.sv
// Controller state machine for the branch history table predictor.
// Depends on bhtp_pkg.
module bhtp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bhtp_pkg::t_dp_sts i_sts,
    output bhtp_pkg::t_dp_cmd o_cmd
);
    import bhtp_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       eval_ok;

    assign eval_ok = i_sts.is_update || i_sts.out_free;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (eval_ok) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/bhtp_datapath.sv
// Datapath: mode register, outcome history, counter table memory,
// counter update and result register. Depends on bhtp_pkg.
module bhtp_datapath #(
    parameter int LOG_TABLE_SIZE = bhtp_pkg::LOG_TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bhtp_pkg::t_dp_cmd           i_cmd,
    output bhtp_pkg::t_dp_sts           o_sts,
    input  logic                        i_cfg_valid,
    input  logic [bhtp_pkg::MODE_W-1:0] i_index_mode,
    input  logic                        i_command,
    input  logic [63:0]                 i_branch_address,
    input  logic                        i_was_taken,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_predict_taken
);
    import bhtp_pkg::*;

    localparam int DEPTH = 1 << LOG_TABLE_SIZE;

    logic [MODE_W-1:0]         r_mode;
    logic [LOG_TABLE_SIZE-1:0] r_hist;
    logic [LOG_TABLE_SIZE-1:0] r_clr_addr;
    logic [LOG_TABLE_SIZE-1:0] r_index;
    logic [LOG_TABLE_SIZE-1:0] n_index;
    logic                      r_cmd;
    logic                      r_taken;
    logic [CTR_W-1:0]          r_rd_data;
    logic [CTR_W-1:0]          n_ctr;
    logic                      r_out_valid;
    logic                      r_out_taken;
    logic [LOG_TABLE_SIZE-1:0] pc_idx;
    logic                      is_update;
    logic                      hist_mode;
    logic                      wr_en;
    logic [LOG_TABLE_SIZE-1:0] wr_addr;
    logic [CTR_W-1:0]          wr_data;

    logic [CTR_W-1:0] mem [0:DEPTH-1];

    assign pc_idx    = i_branch_address[LOG_TABLE_SIZE+1:2];
    assign is_update = (r_cmd == CMD_UPDATE);
    assign hist_mode = r_mode inside {MODE_GLOBAL, MODE_GSHARE};

    always_comb begin
        case (r_mode)
            MODE_GLOBAL: n_index = r_hist;
            MODE_GSHARE: n_index = pc_idx ^ r_hist;
            default:     n_index = pc_idx;  // local, and the unused code
        endcase
    end

    // saturating 2-bit counter step
    always_comb begin
        n_ctr = r_rd_data;
        if (r_taken && r_rd_data != CTR_MAX) begin
            n_ctr = r_rd_data + 2'd1;
        end else if (!r_taken && r_rd_data != CTR_MIN) begin
            n_ctr = r_rd_data - 2'd1;
        end
    end

    assign wr_en   = i_cmd.clr_en || (i_cmd.eval && is_update);
    assign wr_addr = i_cmd.clr_en ? r_clr_addr : r_index;
    assign wr_data = i_cmd.clr_en ? CTR_RESET : n_ctr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_index <= n_index;
            r_cmd   <= i_command;
            r_taken <= i_was_taken;
        end
        if (i_cmd.eval && !is_update) begin
            r_out_taken <= (r_rd_data >= CTR_RESET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LOCAL;
            r_hist      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_index_mode;
            end
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + LOG_TABLE_SIZE'(1);
            end
            if (i_cmd.eval && is_update && hist_mode) begin
                r_hist <= LOG_TABLE_SIZE'({r_hist, r_taken});
            end
            if (i_cmd.eval && !is_update) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == {LOG_TABLE_SIZE{1'b1}});
    assign o_sts.is_update = is_update;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_predict_taken = r_out_taken;

endmodule
